// ===== hdl/c2_debug_frame_master_assert.svh =====
// Assertion macros shared by the debug frame master RTL.
// Needs a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef C2_DEBUG_FRAME_MASTER_ASSERT_SVH
`define C2_DEBUG_FRAME_MASTER_ASSERT_SVH

// Property checked on every rising edge outside reset.
`define C2DFM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Implication whose property is checked in the cycle after the condition.
`define C2DFM_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

// ===== hdl/c2dfm_pkg.sv =====
// Types and constants for the two-wire debug frame master.
// No dependencies; imported by every RTL module of the block.
package c2dfm_pkg;

    localparam int unsigned TICK_W = 16;

    // Input op codes
    localparam logic [2:0] OP_TICK  = 3'd0;
    localparam logic [2:0] OP_RESET = 3'd1;
    localparam logic [2:0] OP_WADDR = 3'd2;
    localparam logic [2:0] OP_RADDR = 3'd3;
    localparam logic [2:0] OP_WDATA = 3'd4;
    localparam logic [2:0] OP_RDATA = 3'd5;

    // Configuration register indexes
    localparam logic [1:0] REG_CLK_LOW  = 2'd0;
    localparam logic [1:0] REG_CLK_HIGH = 2'd1;
    localparam logic [1:0] REG_RST_LOW  = 2'd2;
    localparam logic [1:0] REG_RST_HIGH = 2'd3;

    localparam logic [TICK_W-1:0] RST_CLK_LOW  = 16'd10;
    localparam logic [TICK_W-1:0] RST_CLK_HIGH = 16'd12;
    localparam logic [TICK_W-1:0] RST_RST_LOW  = 16'd10000;
    localparam logic [TICK_W-1:0] RST_RST_HIGH = 16'd10000;

    // Instruction codes sent after the start bit, LSB first
    localparam logic [1:0] INS_WADDR = 2'h3;
    localparam logic [1:0] INS_RADDR = 2'h2;
    localparam logic [1:0] INS_WDATA = 2'h1;
    localparam logic [1:0] INS_RDATA = 2'h0;

    localparam logic [4:0] LAST_SLOT_ADDR = 5'd11;
    localparam logic [4:0] LAST_SLOT_DATA = 5'd14;

    typedef enum logic [2:0] {
        K_IDLE  = 3'd0,
        K_RESET = 3'd1,
        K_WADDR = 3'd2,
        K_RADDR = 3'd3,
        K_WDATA = 3'd4,
        K_RDATA = 3'd5
    } t_kind;

    // LOW and HIGH double as the driven level
    typedef enum logic [2:0] {
        S_LOW  = 3'd0,
        S_HIGH = 3'd1,
        S_DATA = 3'd2,
        S_READ = 3'd3,
        S_WAIT = 3'd4
    } t_slot;

    typedef struct packed {
        logic [TICK_W-1:0] clk_low;
        logic [TICK_W-1:0] clk_high;
        logic [TICK_W-1:0] rst_low;
        logic [TICK_W-1:0] rst_high;
    } t_cfg;

    typedef struct packed {
        logic       clock_pin;
        logic       data_drive;
        logic       data_enable;
        logic       busy_res;
        logic       frame_done;
        logic [7:0] read_byte;
        logic       rejected;
    } t_result;

endpackage

// ===== hdl/c2dfm_seq.sv =====
// Bit-slot sequencer: frame state, phase counter and per-beat result.
// Depends on c2dfm_pkg and the assertion macro header.
`include "c2_debug_frame_master_assert.svh"
module c2dfm_seq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  logic [2:0]         i_op,
    input  logic [7:0]         i_payload,
    input  logic               i_pin_level,
    input  c2dfm_pkg::t_cfg    i_cfg,
    output c2dfm_pkg::t_result o_result
);
    import c2dfm_pkg::*;

    t_kind       r_kind, n_kind;
    logic [4:0]  r_slot, n_slot;
    logic [15:0] r_phase, n_phase;
    logic        r_high, n_high;
    logic [7:0]  r_shift, n_shift;
    logic        r_latch, n_latch;
    logic [7:0]  r_last_read, n_last_read;

    logic        busy;
    logic        done;
    logic        rej;
    logic        enable;
    logic [15:0] limit_raw;
    logic [15:0] limit;
    logic [15:0] phase_inc;
    t_slot       cur_slot;
    t_slot       new_slot;
    logic [4:0]  last_slot;

    function automatic t_slot slot_kind(input t_kind k, input logic [4:0] i);
        logic [1:0] ins;
        t_slot      s;
        unique case (k)
            K_WADDR: ins = INS_WADDR;
            K_RADDR: ins = INS_RADDR;
            K_WDATA: ins = INS_WDATA;
            default: ins = INS_RDATA;
        endcase
        if (i == 5'd0) begin
            s = S_LOW;
        end else if (i <= 5'd2) begin
            s = ins[i[1]] ? S_HIGH : S_LOW;
        end else if (k == K_WADDR) begin
            s = (i <= 5'd10) ? S_DATA : S_LOW;
        end else if (k == K_RADDR) begin
            s = (i <= 5'd10) ? S_READ : S_LOW;
        end else if (i <= 5'd4) begin
            s = S_LOW;  // length field, always zero
        end else if (k == K_WDATA) begin
            if (i <= 5'd12)      s = S_DATA;
            else if (i == 5'd13) s = S_WAIT;
            else                 s = S_LOW;
        end else begin
            if (i == 5'd5)       s = S_WAIT;
            else if (i <= 5'd13) s = S_READ;
            else                 s = S_LOW;
        end
        return s;
    endfunction

    assign busy      = (r_kind != K_IDLE);
    assign cur_slot  = slot_kind(r_kind, r_slot);
    assign phase_inc = r_phase + 16'd1;
    assign last_slot = (r_kind == K_WADDR || r_kind == K_RADDR) ? LAST_SLOT_ADDR
                                                                : LAST_SLOT_DATA;

    always_comb begin
        if (!r_high) limit_raw = (r_kind == K_RESET) ? i_cfg.rst_low : i_cfg.clk_low;
        else         limit_raw = (r_kind == K_RESET) ? i_cfg.rst_high : i_cfg.clk_high;
        limit = (limit_raw == 16'd0) ? 16'd1 : limit_raw;
    end

    // Next state
    always_comb begin
        n_kind      = r_kind;
        n_slot      = r_slot;
        n_phase     = r_phase;
        n_high      = r_high;
        n_shift     = r_shift;
        n_last_read = r_last_read;
        done        = 1'b0;
        rej         = 1'b0;
        if (i_op == OP_TICK) begin
            if (busy) begin
                if (phase_inc < limit) begin
                    n_phase = phase_inc;
                end else begin
                    n_phase = 16'd0;
                    if (!r_high) begin
                        n_high = 1'b1;
                    end else if (r_kind == K_RESET) begin
                        n_kind = K_IDLE;
                        done   = 1'b1;
                    end else if (cur_slot == S_WAIT && !i_pin_level) begin
                        n_high = 1'b0;  // target not ready: repeat the wait slot
                    end else begin
                        n_high = 1'b0;
                        if (cur_slot == S_READ) begin
                            n_shift = {i_pin_level, r_shift[7:1]};
                            if ((r_kind == K_RADDR && r_slot == 5'd10) ||
                                (r_kind == K_RDATA && r_slot == 5'd13))
                                n_last_read = n_shift;
                        end else if (cur_slot == S_DATA) begin
                            n_shift = {1'b0, r_shift[7:1]};
                        end
                        if (r_slot >= last_slot) begin
                            n_kind = K_IDLE;
                            n_slot = 5'd0;
                            n_high = 1'b1;
                            done   = 1'b1;
                        end else begin
                            n_slot = r_slot + 5'd1;
                        end
                    end
                end
            end
        end else if (i_op <= OP_RDATA) begin
            if (busy) begin
                rej = 1'b1;
            end else begin
                n_kind  = t_kind'(i_op);
                n_slot  = 5'd0;
                n_phase = 16'd0;
                n_high  = 1'b0;
                n_shift = (i_op == OP_WADDR || i_op == OP_WDATA) ? i_payload : 8'd0;
            end
        end
    end

    assign new_slot = slot_kind(n_kind, n_slot);

    // Pin levels after the beat
    always_comb begin
        enable  = 1'b1;
        n_latch = r_latch;
        if (n_kind != K_IDLE && n_kind != K_RESET) begin
            unique case (new_slot)
                S_READ, S_WAIT: enable = 1'b0;
                S_DATA:         n_latch = n_shift[0];
                S_HIGH:         n_latch = 1'b1;
                S_LOW:          n_latch = 1'b0;
                default:        n_latch = 1'b0;
            endcase
        end
        o_result.clock_pin   = n_high;
        o_result.data_drive  = enable & n_latch;
        o_result.data_enable = enable;
        o_result.busy_res    = (n_kind != K_IDLE);
        o_result.frame_done  = done;
        o_result.read_byte   = n_last_read;
        o_result.rejected    = rej;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind      <= K_IDLE;
            r_slot      <= 5'd0;
            r_phase     <= 16'd0;
            r_high      <= 1'b1;
            r_shift     <= 8'd0;
            r_latch     <= 1'b0;
            r_last_read <= 8'd0;
        end else if (i_accept) begin
            r_kind      <= n_kind;
            r_slot      <= n_slot;
            r_phase     <= n_phase;
            r_high      <= n_high;
            r_shift     <= n_shift;
            r_latch     <= n_latch;
            r_last_read <= n_last_read;
        end
    end

    `C2DFM_ASSERT(a_done_ends_busy, !(i_accept && done) || !o_result.busy_res,
        "frame_done with busy still set")
    `C2DFM_ASSERT(a_reject_only_busy, !(i_accept && rej) || busy,
        "command rejected while idle")
    `C2DFM_ASSERT(a_slot_range, r_slot <= LAST_SLOT_DATA,
        "slot index past end of frame")
    `C2DFM_ASSERT(a_idle_clean, busy || (r_high && r_phase == 16'd0 && r_slot == 5'd0),
        "idle with clock low or counters running")
endmodule

// ===== hdl/c2dfm_outq.sv =====
// Two-entry result buffer that decouples the sequencer from output stalls.
// Depends on c2dfm_pkg and the assertion macro header.
`include "c2_debug_frame_master_assert.svh"
module c2dfm_outq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  c2dfm_pkg::t_result i_data,
    output logic               o_full,
    output logic               o_valid,
    input  logic               i_stall,
    output c2dfm_pkg::t_result o_data
);
    import c2dfm_pkg::*;

    t_result    r_head, n_head;
    t_result    r_tail, n_tail;
    logic [1:0] r_count, n_count;
    logic       pop;

    assign o_valid = (r_count != 2'd0);
    assign o_full  = (r_count == 2'd2);
    assign o_data  = r_head;
    assign pop     = o_valid && !i_stall;

    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        unique case (r_count)
            2'd0: begin
                if (i_push) begin
                    n_head  = i_data;
                    n_count = 2'd1;
                end
            end
            2'd1: begin
                if (i_push && pop) begin
                    n_head = i_data;
                end else if (i_push) begin
                    n_tail  = i_data;
                    n_count = 2'd2;
                end else if (pop) begin
                    n_count = 2'd0;
                end
            end
            2'd2: begin
                if (pop) begin
                    n_head  = r_tail;
                    n_count = 2'd1;
                end
            end
            default: n_count = 2'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 2'd0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_head <= n_head;
        r_tail <= n_tail;
    end

    `C2DFM_ASSERT(a_count_range, r_count != 2'd3, "result buffer count out of range")
    `C2DFM_ASSERT_NEXT(a_full_holds, o_full && i_stall,
        o_full && $stable(r_head) && $stable(r_tail), "stalled full buffer changed")
    `C2DFM_ASSERT_NEXT(a_drain, r_count == 2'd1 && pop && !i_push, !o_valid,
        "buffer not empty after last beat taken")
endmodule

// ===== hdl/c2_debug_frame_master.sv =====
// Top level of the two-wire debug frame master: configuration registers,
// sequencer and result buffer. Depends on c2dfm_pkg, c2dfm_seq, c2dfm_outq.
//
// Usage: each input beat (i_in_valid, o_in_stall) carries an op: a tick with
// the sampled data pin level, or a reset-pulse / address / data command.
// Every accepted beat yields exactly one result beat (o_out_valid,
// i_out_stall) with the clock and data pin levels after that beat, busy,
// frame-done, the last read byte and a reject flag for commands sent while
// busy. A beat is processed in the cycle it is accepted; its result is
// registered into the result buffer. Throughput is one beat per cycle
// while o_in_stall is low. A two-entry result buffer absorbs output
// stalls; o_in_stall rises only when both entries hold untaken results, and
// no result is dropped. Configuration writes (i_cfg_we) are registered
// and should be made while no frame is running. Synchronous reset returns
// the sequencer to idle with the clock high, empties the buffer and loads
// the default tick counts.
module c2_debug_frame_master (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_op,
    input  logic [7:0]  i_payload,
    input  logic        i_pin_level,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_clock_pin,
    output logic        o_data_drive,
    output logic        o_data_enable,
    output logic        o_busy_res,
    output logic        o_frame_done,
    output logic [7:0]  o_read_byte,
    output logic        o_rejected,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    import c2dfm_pkg::*;

    t_cfg    r_cfg;
    t_result seq_result;
    t_result out_result;
    logic    in_accept;
    logic    q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.clk_low  <= RST_CLK_LOW;
            r_cfg.clk_high <= RST_CLK_HIGH;
            r_cfg.rst_low  <= RST_RST_LOW;
            r_cfg.rst_high <= RST_RST_HIGH;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_CLK_LOW:  r_cfg.clk_low  <= i_cfg_data;
                REG_CLK_HIGH: r_cfg.clk_high <= i_cfg_data;
                REG_RST_LOW:  r_cfg.rst_low  <= i_cfg_data;
                REG_RST_HIGH: r_cfg.rst_high <= i_cfg_data;
                default:      r_cfg.clk_low  <= i_cfg_data;
            endcase
        end
    end

    assign o_in_stall = q_full;
    assign in_accept  = i_in_valid && !q_full;

    c2dfm_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (in_accept),
        .i_op        (i_op),
        .i_payload   (i_payload),
        .i_pin_level (i_pin_level),
        .i_cfg       (r_cfg),
        .o_result    (seq_result)
    );

    c2dfm_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (in_accept),
        .i_data  (seq_result),
        .o_full  (q_full),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_data  (out_result)
    );

    assign o_clock_pin   = out_result.clock_pin;
    assign o_data_drive  = out_result.data_drive;
    assign o_data_enable = out_result.data_enable;
    assign o_busy_res    = out_result.busy_res;
    assign o_frame_done  = out_result.frame_done;
    assign o_read_byte   = out_result.read_byte;
    assign o_rejected    = out_result.rejected;
endmodule
